// ----- design/dqr_pkg.sv -----
// Shared widths, operation codes and status codes of the deque block.
package dqr_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_DROP_HEAD = 3'd1,
        OP_DROP_TAIL = 3'd2,
        OP_DELETE    = 3'd3,
        OP_CLEAR     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

// ----- design/dqr_ifs.sv -----
// Request and response channel interfaces of the deque block.
interface dqr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [dqr_pkg::OP_W-1:0]             operation;
    logic signed [dqr_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dqr_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [dqr_pkg::STATUS_W-1:0]         status;
    logic [dqr_pkg::COUNT_W-1:0]          entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ----- design/dqr_mem.sv -----
// Entry store: one write port, one read port with registered read data.
module dqr_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/deque_with_remove_by_value.sv -----
// Top level: bounded deque with delete-by-value over a circular entry store.
// Append, drop head, drop tail and clear: registered result beat, held in S_DONE if output busy.
// Delete value: the store streams one entry per cycle through its read port,
//   compares it and moves every later entry up one slot behind the first match.
// One request in work at a time; a new request is taken while a result beat waits.
// Reset clears head index, entry count and handshake state; the store is not cleared.
module deque_with_remove_by_value #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    dqr_req_if.sink    req,
    dqr_rsp_if.source  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             rd_pos_reg, rd_pos_next;
    logic [AW-1:0]             rd_slot_reg, rd_slot_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      found_reg, found_next;
    logic                      out_vld_reg, out_vld_next;
    logic [AW-1:0]             slot_d1_reg, slot_d1_next;
    logic [AW-1:0]             slot_d2_reg, slot_d2_next;
    logic [DATA_WIDTH-1:0]     word_reg, word_next;
    dqr_pkg::status_t          pend_status_reg, pend_status_next;
    dqr_pkg::status_t          out_status_reg, out_status_next;
    logic [dqr_pkg::COUNT_W-1:0] out_count_reg, out_count_next;

    logic                      accept;
    logic                      out_free;
    logic                      fin;
    dqr_pkg::status_t          fin_status;
    logic [DATA_WIDTH-1:0]     word_in;
    logic [AW:0]               tail_sum;
    logic [AW-1:0]             tail_slot;
    logic                      match;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [DATA_WIDTH-1:0]     wr_data;
    logic                      rd_en;
    logic [DATA_WIDTH-1:0]     rd_data;

    dqr_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_slot_reg),
        .rd_data (rd_data)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign accept          = req.valid && req.ready;
    assign out_free        = !out_vld_reg || rsp.ready;
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;

    assign word_in   = DATA_WIDTH'($unsigned(req.value));
    assign tail_sum  = {1'b0, head_reg} + {1'b0, count_reg[AW-1:0]};
    assign tail_slot = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                    : tail_sum[AW-1:0];
    assign match     = (rd_data == word_reg);
    assign rd_en     = (state_reg == S_RUN) && (rd_pos_reg != count_reg);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        rd_pos_next      = rd_pos_reg;
        rd_slot_next     = rd_slot_reg;
        rd_vld_next      = 1'b0;
        found_next       = found_reg;
        slot_d1_next     = slot_d1_reg;
        slot_d2_next     = slot_d1_reg;
        word_next        = word_reg;
        pend_status_next = pend_status_reg;
        out_vld_next     = out_vld_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        fin              = 1'b0;
        fin_status       = dqr_pkg::ST_OK;
        wr_en            = 1'b0;
        wr_addr          = tail_slot;
        wr_data          = word_in;

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fin = 1'b1;
                    unique case (dqr_pkg::op_t'(req.operation))
                        dqr_pkg::OP_APPEND:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                fin_status = dqr_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        dqr_pkg::OP_DROP_HEAD:
                        begin
                            if (count_reg == '0)
                            begin
                                fin_status = dqr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = (head_reg == AW'(DEPTH - 1)) ? '0
                                                                          : head_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dqr_pkg::OP_DROP_TAIL:
                        begin
                            if (count_reg == '0)
                            begin
                                fin_status = dqr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dqr_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin_status = dqr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                fin          = 1'b0;
                                word_next    = word_in;
                                rd_pos_next  = '0;
                                rd_slot_next = head_reg;
                                found_next   = 1'b0;
                                state_next   = S_RUN;
                            end
                        end
                        dqr_pkg::OP_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            fin_status = dqr_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (rd_en)
                begin
                    rd_vld_next  = 1'b1;
                    rd_pos_next  = rd_pos_reg + CW'(1);
                    rd_slot_next = (rd_slot_reg == AW'(DEPTH - 1)) ? '0
                                                                   : rd_slot_reg + AW'(1);
                    slot_d1_next = rd_slot_reg;
                end
                if (rd_vld_reg)
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = slot_d2_reg;
                        wr_data = rd_data;
                    end
                    else if (match)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (!rd_en && rd_vld_reg)
                begin
                    fin = 1'b1;
                    if (found_reg || match)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        fin_status = dqr_pkg::ST_NOT_FOUND;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = pend_status_reg;
                    out_count_next  = dqr_pkg::COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                out_vld_next    = 1'b1;
                out_status_next = fin_status;
                out_count_next  = dqr_pkg::COUNT_W'(count_next);
                state_next      = S_IDLE;
            end
            else
            begin
                pend_status_next = fin_status;
                state_next       = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rd_pos_reg  <= '0;
            rd_slot_reg <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            rd_pos_reg  <= rd_pos_next;
            rd_slot_reg <= rd_slot_next;
            rd_vld_reg  <= rd_vld_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_d1_reg     <= slot_d1_next;
        slot_d2_reg     <= slot_d2_next;
        word_reg        <= word_next;
        pend_status_reg <= pend_status_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_slot_reg))
        else $error("store read and write hit the same slot");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (count_reg != '0))
        else $error("delete search on an empty list");

    a_delete_enters_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.operation == dqr_pkg::OP_DELETE) && (count_reg != '0))
        |=> (state_reg == S_RUN))
        else $error("delete request did not start a search");

    a_done_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> out_vld_reg)
        else $error("result held back while the output register is free");

endmodule
